### sv/meg_pkg.sv
// meg_pkg: shared types and constants of the mouse event generator
`timescale 1ns / 1ps

package meg_pkg;

  localparam int BUTTON_COUNT_DEF = 3;

  // event codes
  localparam logic [3:0] CODE_MOVE  = 4'd6;
  localparam logic [3:0] CODE_IDLE  = 4'd7;
  localparam logic [3:0] CODE_WHEEL = 4'd8;

  // register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_MAX_X    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_MAX_Y    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_RELATIVE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BUTTONS_SWAPPED = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_DELAY      = 3'd5;

  // register reset values
  localparam logic [11:0] SCREEN_MAX_X_RST = 12'd639;
  localparam logic [11:0] SCREEN_MAX_Y_RST = 12'd479;
  localparam logic [15:0] REPEAT_DELAY_RST = 16'd250;
  localparam logic [15:0] IDLE_DELAY_RST   = 16'd35;

  // cursor starts in the middle of the reset screen
  localparam logic [11:0] CURSOR_X_RST = 12'((int'(SCREEN_MAX_X_RST) + 1) / 2);
  localparam logic [11:0] CURSOR_Y_RST = 12'((int'(SCREEN_MAX_Y_RST) + 1) / 2);

  typedef struct packed {
    logic [11:0] screen_max_x;
    logic [11:0] screen_max_y;
    logic        wheel_relative;
    logic        buttons_swapped;
    logic [15:0] repeat_delay_ms;
    logic [15:0] idle_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] wheel_value;
  } sample_t;

  typedef struct packed {
    logic [11:0]        cursor_x;
    logic [11:0]        cursor_y;
    logic [31:0]        last_sample_time;
    logic [31:0]        last_motion_time;
    logic               idle_reported;
    logic signed [15:0] wheel_absolute;
  } state_t;

endpackage

### sv/mouse_event_generator_top.sv
// mouse_event_generator_top: sample register, event buffer and output register
`timescale 1ns / 1ps

// a sample gives up to BUTTON_COUNT + 2 events, which pass from the sample register
//   through the event buffer to the single output register; a new sample is loaded
//   as the last event pops; the buffer drains one event per cycle unless stalled
// reset: registers take their documented values, cursor goes to the middle of the
//   reset screen, buttons read as released, all timestamps are zero

module mouse_event_generator_top #(
  parameter int BUTTON_COUNT = meg_pkg::BUTTON_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [meg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [meg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [31:0]                       sample_time,
  input  logic signed [15:0]                delta_x,
  input  logic signed [15:0]                delta_y,
  input  logic signed [15:0]                wheel_value,
  input  logic [BUTTON_COUNT-1:0]           button_bits,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        event_code,
  output logic                              repeat_flag,
  output logic [11:0]                       pos_x,
  output logic [11:0]                       pos_y,
  output logic signed [16:0]                wheel_out,
  output logic [31:0]                       event_time,
  output logic                              last_event
);

  localparam int NSLOT = BUTTON_COUNT + 2;
  localparam int IW    = $clog2(NSLOT);

  meg_pkg::cfg_t cfg;

  // sample register
  logic                    a_valid;
  meg_pkg::sample_t        a_sample;
  logic [BUTTON_COUNT-1:0] a_buttons;

  // architectural state
  meg_pkg::state_t         st;
  meg_pkg::state_t         st_next;
  logic [BUTTON_COUNT-1:0] held;
  logic [BUTTON_COUNT-1:0] held_next;
  logic [31:0]             stamp [BUTTON_COUNT];
  logic [31:0]             stamp_next [BUTTON_COUNT];

  // step results
  logic [NSLOT-1:0]   step_mask;
  logic [3:0]         step_code [NSLOT];
  logic [NSLOT-1:0]   step_rep;
  logic signed [16:0] step_wheel_evt;

  // event buffer
  logic [NSLOT-1:0]   b_mask;
  logic [NSLOT-1:0]   b_mask_next;
  logic [3:0]         b_code [NSLOT];
  logic [NSLOT-1:0]   b_rep;
  logic [11:0]        b_pos_x;
  logic [11:0]        b_pos_y;
  logic signed [16:0] b_wheel;
  logic signed [16:0] b_wheel_evt;
  logic [31:0]        b_time;

  logic               out_free;
  logic               pop;
  logic               b_load;
  logic [IW-1:0]      pop_idx;
  logic [NSLOT-1:0]   remaining;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_max_x    <= meg_pkg::SCREEN_MAX_X_RST;
      cfg.screen_max_y    <= meg_pkg::SCREEN_MAX_Y_RST;
      cfg.wheel_relative  <= 1'b1;
      cfg.buttons_swapped <= 1'b0;
      cfg.repeat_delay_ms <= meg_pkg::REPEAT_DELAY_RST;
      cfg.idle_delay_ms   <= meg_pkg::IDLE_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        meg_pkg::REG_SCREEN_MAX_X:    cfg.screen_max_x    <= cfg_data[11:0];
        meg_pkg::REG_SCREEN_MAX_Y:    cfg.screen_max_y    <= cfg_data[11:0];
        meg_pkg::REG_WHEEL_RELATIVE:  cfg.wheel_relative  <= cfg_data[0];
        meg_pkg::REG_BUTTONS_SWAPPED: cfg.buttons_swapped <= cfg_data[0];
        meg_pkg::REG_REPEAT_DELAY:    cfg.repeat_delay_ms <= cfg_data;
        meg_pkg::REG_IDLE_DELAY:      cfg.idle_delay_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // lowest pending slot goes out first
  always_comb begin
    pop_idx = '0;
    for (int s = NSLOT - 1; s >= 0; s--) begin
      if (b_mask[s]) begin
        pop_idx = IW'(s);
      end
    end
    remaining = b_mask & ~(NSLOT'(1) << pop_idx);
  end

  assign out_free = !out_valid || !out_stall;
  assign pop      = out_free && (b_mask != '0);
  assign b_load   = a_valid && ((b_mask == '0) || (pop && (remaining == '0)));
  assign in_stall = a_valid && !b_load;

  always_comb begin
    b_mask_next = b_mask;
    if (pop) begin
      b_mask_next = remaining;
    end
    if (b_load) begin
      b_mask_next = step_mask;
    end
  end

  meg_step #(
    .BUTTON_COUNT (BUTTON_COUNT),
    .NSLOT        (NSLOT)
  ) u_step (
    .cfg         (cfg),
    .sample      (a_sample),
    .button_bits (a_buttons),
    .st          (st),
    .held        (held),
    .stamp       (stamp),
    .st_next     (st_next),
    .held_next   (held_next),
    .stamp_next  (stamp_next),
    .slot_mask   (step_mask),
    .slot_code   (step_code),
    .slot_rep    (step_rep),
    .wheel_evt   (step_wheel_evt)
  );

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_sample.sample_time <= sample_time;
      a_sample.delta_x     <= delta_x;
      a_sample.delta_y     <= delta_y;
      a_sample.wheel_value <= wheel_value;
      a_buttons            <= button_bits;
    end
  end

  // state and event buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      st.cursor_x         <= meg_pkg::CURSOR_X_RST;
      st.cursor_y         <= meg_pkg::CURSOR_Y_RST;
      st.last_sample_time <= '0;
      st.last_motion_time <= '0;
      st.idle_reported    <= 1'b0;
      st.wheel_absolute   <= '0;
      held                <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        stamp[i] <= '0;
      end
      b_mask <= '0;
    end else begin
      b_mask <= b_mask_next;
      if (b_load) begin
        st   <= st_next;
        held <= held_next;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
          stamp[i] <= stamp_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      for (int s = 0; s < NSLOT; s++) begin
        b_code[s] <= step_code[s];
      end
      b_rep       <= step_rep;
      b_pos_x     <= st_next.cursor_x;
      b_pos_y     <= st_next.cursor_y;
      b_wheel     <= 17'(a_sample.wheel_value);
      b_wheel_evt <= step_wheel_evt;
      b_time      <= a_sample.sample_time;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      event_code  <= b_code[pop_idx];
      repeat_flag <= b_rep[pop_idx];
      pos_x       <= b_pos_x;
      pos_y       <= b_pos_y;
      // only the wheel event carries the absolute-mode delta
      wheel_out   <= (pop_idx == IW'(1)) ? b_wheel_evt : b_wheel;
      event_time  <= b_time;
      last_event  <= (remaining == '0);
    end
  end

  // a new sample only enters once the buffer is down to its final event
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    b_load |-> ($countones(b_mask) <= 1))
    else $error("event buffer reloaded while events pending");

  a_pop_shows: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped event not shown");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_event) |-> (b_mask != '0))
    else $error("non-final event without a following event");

endmodule

### sv/meg_step.sv
// meg_step: per-sample state update and event slot computation
`timescale 1ns / 1ps

module meg_step #(
  parameter int BUTTON_COUNT = meg_pkg::BUTTON_COUNT_DEF,
  parameter int NSLOT        = BUTTON_COUNT + 2
) (
  input  meg_pkg::cfg_t             cfg,
  input  meg_pkg::sample_t          sample,
  input  logic [BUTTON_COUNT-1:0]   button_bits,
  input  meg_pkg::state_t           st,
  input  logic [BUTTON_COUNT-1:0]   held,
  input  logic [31:0]               stamp [BUTTON_COUNT],
  output meg_pkg::state_t           st_next,
  output logic [BUTTON_COUNT-1:0]   held_next,
  output logic [31:0]               stamp_next [BUTTON_COUNT],
  output logic [NSLOT-1:0]          slot_mask,
  output logic [3:0]                slot_code [NSLOT],
  output logic [NSLOT-1:0]          slot_rep,
  output logic signed [16:0]        wheel_evt
);

  logic [31:0]        now;
  logic [31:0]        since_sample;
  logic [31:0]        since_motion;
  logic [31:0]        since_stamp [BUTTON_COUNT];
  logic signed [17:0] sum_x;
  logic signed [17:0] sum_y;
  logic [11:0]        new_x;
  logic [11:0]        new_y;
  logic               moved;
  logic               idle_due;
  logic               dropped;
  logic signed [16:0] wheel_ext;
  logic signed [16:0] wheel_delta;
  logic [3:0]         id;

  assign now          = sample.sample_time;
  assign since_sample = now - st.last_sample_time;
  assign since_motion = now - st.last_motion_time;
  assign dropped      = since_sample[31];
  assign moved        = (sample.delta_x != 16'sd0) || (sample.delta_y != 16'sd0);
  assign idle_due     = !since_motion[31] && (since_motion[30:0] > 31'(cfg.idle_delay_ms));
  assign wheel_ext    = 17'(sample.wheel_value);
  assign wheel_delta  = wheel_ext - 17'(st.wheel_absolute);

  // clamp a moving axis to [0, max]; an axis that does not move keeps its value
  always_comb begin
    sum_x = $signed({6'b0, st.cursor_x}) + 18'(sample.delta_x);
    sum_y = $signed({6'b0, st.cursor_y}) + 18'(sample.delta_y);
    if (sample.delta_x == 16'sd0) begin
      new_x = st.cursor_x;
    end else if (sum_x[17]) begin
      new_x = '0;
    end else if (sum_x[16:0] > {5'b0, cfg.screen_max_x}) begin
      new_x = cfg.screen_max_x;
    end else begin
      new_x = sum_x[11:0];
    end
    if (sample.delta_y == 16'sd0) begin
      new_y = st.cursor_y;
    end else if (sum_y[17]) begin
      new_y = '0;
    end else if (sum_y[16:0] > {5'b0, cfg.screen_max_y}) begin
      new_y = cfg.screen_max_y;
    end else begin
      new_y = sum_y[11:0];
    end
  end

  always_comb begin
    st_next   = st;
    slot_mask = '0;
    slot_rep  = '0;
    for (int s = 0; s < NSLOT; s++) begin
      slot_code[s] = meg_pkg::CODE_MOVE;
    end
    wheel_evt = wheel_ext;
    held_next = held;
    id        = '0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      stamp_next[i]  = stamp[i];
      since_stamp[i] = now - stamp[i];
    end

    if (!dropped) begin
      st_next.last_sample_time = now;
      st_next.cursor_x         = new_x;
      st_next.cursor_y         = new_y;

      // motion or idle slot
      if (moved) begin
        st_next.last_motion_time = now;
        st_next.idle_reported    = 1'b0;
        slot_mask[0]             = 1'b1;
        slot_code[0]             = meg_pkg::CODE_MOVE;
      end else if (!st.idle_reported && idle_due) begin
        st_next.idle_reported = 1'b1;
        slot_mask[0]          = 1'b1;
        slot_code[0]          = meg_pkg::CODE_IDLE;
      end

      // wheel slot
      slot_code[1] = meg_pkg::CODE_WHEEL;
      if (cfg.wheel_relative) begin
        slot_mask[1] = (sample.wheel_value != 16'sd0);
      end else if (sample.wheel_value != st.wheel_absolute) begin
        slot_mask[1]           = 1'b1;
        wheel_evt              = wheel_delta;
        st_next.wheel_absolute = sample.wheel_value;
      end

      // button slots
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        id = 4'(i);
        if (cfg.buttons_swapped && BUTTON_COUNT >= 2 && i < 2) begin
          id = id ^ 4'd1;
        end
        if (!button_bits[i]) begin
          slot_code[i+2] = 4'((id << 1) | 4'd1);
          if (held[i]) begin
            held_next[i]   = 1'b0;
            stamp_next[i]  = now;
            slot_mask[i+2] = 1'b1;
          end
        end else begin
          slot_code[i+2] = 4'(id << 1);
          if (!held[i]) begin
            held_next[i]   = 1'b1;
            stamp_next[i]  = now;
            slot_mask[i+2] = 1'b1;
          end else if (!since_stamp[i][31] &&
                       since_stamp[i][30:0] > 31'(cfg.repeat_delay_ms)) begin
            stamp_next[i]  = now;
            slot_mask[i+2] = 1'b1;
            slot_rep[i+2]  = 1'b1;
          end
        end
      end
    end
  end

endmodule

### sim/meg_event_checker.sv
// meg_event_checker: event predictor and result comparison for the mouse event generator
`timescale 1ns / 1ps

module meg_event_checker
  import meg_pkg::*;
#(
  parameter int NBTN = BUTTON_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [31:0]             sample_time,
  input  logic signed [15:0]      delta_x,
  input  logic signed [15:0]      delta_y,
  input  logic signed [15:0]      wheel_value,
  input  logic [NBTN-1:0]         button_bits,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [3:0]              event_code,
  input  logic                    repeat_flag,
  input  logic [11:0]             pos_x,
  input  logic [11:0]             pos_y,
  input  logic signed [16:0]      wheel_out,
  input  logic [31:0]             event_time,
  input  logic                    last_event,
  output int                      fail_count,
  output int                      events_due,
  output int                      samples_taken,
  output int                      samples_dropped,
  output int                      events_seen
);

  typedef struct packed {
    logic [3:0]         code;
    logic               rpt;
    logic [11:0]        x;
    logic [11:0]        y;
    logic signed [16:0] wheel;
    logic [31:0]        stamp;
    logic               last;
  } mouse_event_t;

  cfg_t               cfg;
  logic [11:0]        cursor_x;
  logic [11:0]        cursor_y;
  logic [31:0]        last_sample_ms;
  logic [31:0]        last_motion_ms;
  logic               idle_sent;
  logic signed [15:0] wheel_abs;
  logic               held [NBTN];
  logic [31:0]        held_since [NBTN];
  mouse_event_t       due_q [$];

  initial begin
    fail_count      = 0;
    events_due      = 0;
    samples_taken   = 0;
    samples_dropped = 0;
    events_seen     = 0;
  end

  // wrapping timestamps compare by their signed difference
  function automatic int ms_since(logic [31:0] from_ms, logic [31:0] now_ms);
    logic [31:0] diff;
    diff = now_ms - from_ms;
    return $signed(diff);
  endfunction

  function automatic logic [11:0] clamp_axis(logic [11:0] pos, logic signed [15:0] d,
                                             logic [11:0] lim);
    int p;
    p = int'(pos) + int'(d);
    if (p < 0) p = 0;
    if (p > int'(lim)) p = int'(lim);
    return 12'(p);
  endfunction

  function automatic mouse_event_t make_event(logic [3:0] code, logic rpt,
                                              logic signed [16:0] wheel, logic [31:0] now_ms);
    mouse_event_t ev;
    ev.code  = code;
    ev.rpt   = rpt;
    ev.x     = cursor_x;
    ev.y     = cursor_y;
    ev.wheel = wheel;
    ev.stamp = now_ms;
    ev.last  = 1'b0;
    return ev;
  endfunction

  task automatic predict_events(input logic [31:0] now_ms, input logic signed [15:0] dx,
                                input logic signed [15:0] dy, input logic signed [15:0] wh,
                                input logic [NBTN-1:0] bits);
    mouse_event_t evs [$];
    logic [3:0]   id;
    if (ms_since(last_sample_ms, now_ms) < 0) begin
      samples_dropped++;
      return;
    end
    last_sample_ms = now_ms;

    // an axis that does not move keeps its value even past a shrunk screen
    if (dx != 0) cursor_x = clamp_axis(cursor_x, dx, cfg.screen_max_x);
    if (dy != 0) cursor_y = clamp_axis(cursor_y, dy, cfg.screen_max_y);

    if (dx != 0 || dy != 0) begin
      last_motion_ms = now_ms;
      idle_sent = 1'b0;
      evs.push_back(make_event(CODE_MOVE, 1'b0, 17'(wh), now_ms));
    end else if (!idle_sent && ms_since(last_motion_ms, now_ms) > int'(cfg.idle_delay_ms)) begin
      idle_sent = 1'b1;
      evs.push_back(make_event(CODE_IDLE, 1'b0, 17'(wh), now_ms));
    end

    if (cfg.wheel_relative) begin
      if (wh != 0) evs.push_back(make_event(CODE_WHEEL, 1'b0, 17'(wh), now_ms));
    end else if (wh != wheel_abs) begin
      evs.push_back(make_event(CODE_WHEEL, 1'b0, 17'(wh) - 17'(wheel_abs), now_ms));
      wheel_abs = wh;
    end

    for (int i = 0; i < NBTN; i++) begin
      id = 4'(i);
      if (cfg.buttons_swapped && NBTN >= 2 && i < 2) id = id ^ 4'd1;
      if (!bits[i]) begin
        if (held[i]) begin
          held[i] = 1'b0;
          held_since[i] = now_ms;
          evs.push_back(make_event(4'(2 * id + 1), 1'b0, 17'(wh), now_ms));
        end
      end else if (!held[i]) begin
        held[i] = 1'b1;
        held_since[i] = now_ms;
        evs.push_back(make_event(4'(2 * id), 1'b0, 17'(wh), now_ms));
      end else if (ms_since(held_since[i], now_ms) > int'(cfg.repeat_delay_ms)) begin
        held_since[i] = now_ms;
        evs.push_back(make_event(4'(2 * id), 1'b1, 17'(wh), now_ms));
      end
    end

    if (evs.size() != 0) begin
      evs[evs.size() - 1].last = 1'b1;
      foreach (evs[k]) due_q.push_back(evs[k]);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    mouse_event_t want;
    if (rst) begin
      cfg.screen_max_x    = SCREEN_MAX_X_RST;
      cfg.screen_max_y    = SCREEN_MAX_Y_RST;
      cfg.wheel_relative  = 1'b1;
      cfg.buttons_swapped = 1'b0;
      cfg.repeat_delay_ms = REPEAT_DELAY_RST;
      cfg.idle_delay_ms   = IDLE_DELAY_RST;
      cursor_x       = CURSOR_X_RST;
      cursor_y       = CURSOR_Y_RST;
      last_sample_ms = '0;
      last_motion_ms = '0;
      idle_sent      = 1'b0;
      wheel_abs      = '0;
      for (int i = 0; i < NBTN; i++) begin
        held[i] = 1'b0;
        held_since[i] = '0;
      end
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_MAX_X:    cfg.screen_max_x    = cfg_data[11:0];
          REG_SCREEN_MAX_Y:    cfg.screen_max_y    = cfg_data[11:0];
          REG_WHEEL_RELATIVE:  cfg.wheel_relative  = cfg_data[0];
          REG_BUTTONS_SWAPPED: cfg.buttons_swapped = cfg_data[0];
          REG_REPEAT_DELAY:    cfg.repeat_delay_ms = cfg_data;
          REG_IDLE_DELAY:      cfg.idle_delay_ms   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        samples_taken++;
        predict_events(sample_time, delta_x, delta_y, wheel_value, button_bits);
      end
      if (out_valid && !out_stall) begin
        events_seen++;
        if (due_q.size() == 0) begin
          fail_count++;
          $error("unexpected event: code 0x%0h time 0x%0h", event_code, event_time);
        end else begin
          want = due_q.pop_front();
          check_field("event_code", 32'(want.code), 32'(event_code));
          check_field("repeat_flag", 32'(want.rpt), 32'(repeat_flag));
          check_field("pos_x", 32'(want.x), 32'(pos_x));
          check_field("pos_y", 32'(want.y), 32'(pos_y));
          check_field("wheel_out", 32'(want.wheel), 32'(wheel_out));
          check_field("event_time", want.stamp, event_time);
          check_field("last_event", 32'(want.last), 32'(last_event));
        end
      end
    end
    events_due <= due_q.size();
  end

endmodule

### sim/tb_mouse_event_generator_top.sv
// tb_mouse_event_generator_top: stimulus, flow control and verdict for the mouse event generator
`timescale 1ns / 1ps

module tb_mouse_event_generator_top;
  import meg_pkg::*;

  localparam int NBTN            = BUTTON_COUNT_DEF;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 8;
  localparam int PHASE_SAMPLES   = 48;

  // indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  // register settings of the random phases
  localparam int PH_MAX_X [PHASES] = '{639, 4095, 0, 100, 1919, 4095, 31, 639};
  localparam int PH_MAX_Y [PHASES] = '{479, 4095, 0, 50, 1079, 0, 4095, 479};
  localparam int PH_REL   [PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0};
  localparam int PH_SWAP  [PHASES] = '{0, 1, 1, 0, 0, 1, 0, 0};
  localparam int PH_REP   [PHASES] = '{250, 0, 65535, 30, 100, 500, 1, 250};
  localparam int PH_IDLE  [PHASES] = '{35, 0, 65535, 10, 50, 200, 1, 35};
  localparam int SEND_GAP [4] = '{0, 47, 0, 38};
  localparam int RECV_GAP [4] = '{0, 0, 47, 38};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [31:0]            sample_time = '0;
  logic signed [15:0]     delta_x = '0;
  logic signed [15:0]     delta_y = '0;
  logic signed [15:0]     wheel_value = '0;
  logic [NBTN-1:0]        button_bits = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [3:0]             event_code;
  logic                   repeat_flag;
  logic [11:0]            pos_x;
  logic [11:0]            pos_y;
  logic signed [16:0]     wheel_out;
  logic [31:0]            event_time;
  logic                   last_event;

  int fail_count, events_due, samples_taken, samples_dropped, events_seen;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  mouse_event_generator_top #(.BUTTON_COUNT(NBTN)) dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .sample_time, .delta_x, .delta_y, .wheel_value, .button_bits,
    .out_valid, .out_stall, .event_code, .repeat_flag, .pos_x, .pos_y, .wheel_out,
    .event_time, .last_event
  );

  meg_event_checker #(.NBTN(NBTN)) u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .sample_time, .delta_x, .delta_y, .wheel_value, .button_bits,
    .out_valid, .out_stall, .event_code, .repeat_flag, .pos_x, .pos_y, .wheel_out,
    .event_time, .last_event,
    .fail_count, .events_due, .samples_taken, .samples_dropped, .events_seen
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still due", cycle_count, events_due);
      $display("FAIL mouse_event_generator_top");
      $finish;
    end
  end

  // event receiver: random stalls, or a long hold-off when a new token shows up
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper data bits are filled with noise, the block must drop them
  task automatic load_settings(input logic [11:0] mx, input logic [11:0] my, input logic rel,
                               input logic swap, input logic [15:0] rep, input logic [15:0] idl);
    write_reg(REG_SCREEN_MAX_X, {4'($urandom), mx});
    write_reg(REG_SCREEN_MAX_Y, {4'($urandom), my});
    write_reg(REG_WHEEL_RELATIVE, {15'($urandom), rel});
    write_reg(REG_BUTTONS_SWAPPED, {15'($urandom), swap});
    write_reg(REG_REPEAT_DELAY, rep);
    write_reg(REG_IDLE_DELAY, idl);
    write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
  endtask

  task automatic send_sample(input logic [31:0] t, input logic signed [15:0] dx,
                             input logic signed [15:0] dy, input logic signed [15:0] wh,
                             input logic [NBTN-1:0] bits);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid    <= 1'b1;
    sample_time <= t;
    delta_x     <= dx;
    delta_y     <= dy;
    wheel_value <= wh;
    button_bits <= bits;
    do @(posedge clk); while (in_stall);
  endtask

  // a dropped sample gives no event, so pad a few cycles after the queue empties
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] random_motion();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return '0;
    if (r < 80) return 16'(int'($urandom_range(40)) - 20);
    if (r < 92) return 16'(int'($urandom_range(1200)) - 600);
    return 16'($urandom);
  endfunction

  initial begin
    logic [31:0]        t;
    logic [31:0]        now_ms;
    logic [31:0]        step;
    logic signed [15:0] wheel_now;
    logic [NBTN-1:0]    btn_state;
    int unsigned        r;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: idle timing, extremes of motion and wheel, all buttons
    send_sample(32'd10, 0, 0, 0, 3'b000);
    send_sample(32'd10, 0, 0, 0, 3'b000);
    send_sample(32'd36, 0, 0, 0, 3'b000);
    send_sample(32'd101, 32767, -32768, 32767, 3'b111);
    send_sample(32'd102, -32768, 32767, -32768, 3'b111);
    send_sample(32'd50, 5, 5, 5, 3'b000);              // time runs backwards
    send_sample(32'd137, 0, 0, 0, 3'b111);             // no idle exactly at the delay
    send_sample(32'd138, 0, 0, 0, 3'b111);
    send_sample(32'd351, 0, 0, 0, 3'b111);             // no repeat exactly at the delay
    send_sample(32'd352, 0, 0, 0, 3'b111);
    send_sample(32'd353, 0, 0, 1, 3'b010);
    send_sample(32'd354, 0, 0, 0, 3'b101);
    settle();

    // screen shrunk under the cursor, absolute wheel, swapped buttons
    load_settings(12'd0, 12'd100, 1'b0, 1'b1, 16'd250, 16'd35);
    send_sample(32'd400, -3, 0, 5, 3'b001);
    send_sample(32'd401, 0, 1, 5, 3'b001);
    send_sample(32'd402, 0, 0, -32768, 3'b011);
    send_sample(32'd403, 0, 0, 32767, 3'b011);
    send_sample(32'd404, 0, 0, 32767, 3'b000);
    settle();

    // zero delays, full screen, timestamp wrap
    load_settings(12'd4095, 12'd4095, 1'b1, 1'b1, 16'd0, 16'd0);
    send_sample(32'd405, 1, 1, 0, 3'b111);
    send_sample(32'd405, 0, 0, 0, 3'b111);
    send_sample(32'd406, 0, 0, 0, 3'b111);
    send_sample(32'h8000_0195, 0, 0, 0, 3'b111);
    send_sample(32'hFFFF_FFF0, 0, 0, 0, 3'b111);
    send_sample(32'h0000_0010, 100, -100, 0, 3'b111);
    send_sample(32'h8000_0011, 1, 1, 1, 3'b000);       // half a wrap ahead reads as backwards
    settle();

    // back to absolute wheel: the last absolute reading is kept
    load_settings(12'd4095, 12'd4095, 1'b0, 1'b1, 16'd0, 16'd0);
    send_sample(32'h0000_0020, 0, 0, 32767, 3'b000);
    settle();

    now_ms    = 32'h0000_0020;
    wheel_now = 16'sd32767;
    btn_state = '0;
    for (int p = 0; p < PHASES; p++) begin
      load_settings(12'(PH_MAX_X[p]), 12'(PH_MAX_Y[p]), 1'(PH_REL[p]), 1'(PH_SWAP[p]),
                    16'(PH_REP[p]), 16'(PH_IDLE[p]));
      sender_idle_pct = SEND_GAP[p % 4];
      stall_pct <= RECV_GAP[p % 4];
      // receiver goes quiet while the sender keeps pushing, so the event buffer fills
      if (p == 4) hold_token <= hold_token + 1;

      for (int k = 0; k < PHASE_SAMPLES; k++) begin
        r = $urandom_range(99);
        if (r < 70) t = now_ms + $urandom_range(40);
        else if (r < 85) t = now_ms + $urandom_range(600, 41);
        else if (r < 90) t = now_ms + $urandom_range(32'h7FFF_FFFF);
        else if (r < 95) t = now_ms - $urandom_range(2000, 1);
        else t = $urandom;
        step = t - now_ms;
        if (!step[31]) now_ms = t;

        r = $urandom_range(99);
        if (r < 40) wheel_now = '0;
        else if (r >= 90) wheel_now = 16'($urandom);
        else if (r >= 65) wheel_now = wheel_now + 16'(int'($urandom_range(10)) - 5);

        if ($urandom_range(99) < 5) begin
          btn_state = NBTN'($urandom);
        end else begin
          for (int b = 0; b < NBTN; b++)
            if ($urandom_range(99) < 25) btn_state[b] = ~btn_state[b];
        end

        send_sample(t, random_motion(), random_motion(), wheel_now, btn_state);
      end
      settle();
    end

    $display("covered %0d samples (%0d out of order and dropped) and %0d events",
             samples_taken, samples_dropped, events_seen);
    $display("across %0d register settings with idle, stall and hold-off on both channels",
             PHASES + 4);
    if (fail_count == 0) begin
      $display("PASS mouse_event_generator_top");
    end else begin
      $display("FAIL mouse_event_generator_top");
    end
    $finish;
  end

endmodule
